[sv/mm3_pkg.sv]
`default_nettype none

package mm3_pkg;

    localparam logic [31:0] MM3_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM3_C2 = 32'h1b873593;
    localparam logic [31:0] MM3_N  = 32'he6546b64;
    localparam logic [31:0] MM3_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM3_F2 = 32'hc2b2ae35;

    localparam logic [2:0] MM3_FULL_WORD = 3'd4;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // one mixed key on its way from the front to the back
    typedef struct packed {
        logic [31:0] k;
        logic [2:0]  vb;
        logic        last;
    } mm3_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mm3_q_status_t;

endpackage

`default_nettype wire

[sv/murmur3_32_hash_core.sv]
// murmur3_32_hash_core: streaming MurmurHash3 x86_32, seed zero
//
// input channel (in_valid/in_ready): one 32-bit little-endian word per
// transfer with valid_bytes (0..4, larger counts act as 4) and last.
// a word of one to three bytes is mixed as a tail; zero bytes add nothing.
// output channel (out_valid/out_ready): one hash per message, sent after
// the transfer that carries last; a message of zero bytes gives 0.
//
// the front runs the two key multiplies in a two-stage pipeline and
// feeds a four-entry queue; the back folds one key per cycle into the
// running hash, so words stream at one per cycle except while the back
// finalizes a message (fold, two fmix multiply steps, output load).
// the last word passes both front stages, the queue, the fold, both
// fmix multiply steps and the output register before out_valid rises.
// a stalled receiver holds the hash in the output register while the
// back keeps folding words of the next message; once the next final hash
// is ready it waits, the queue fills and in_ready drops.
// reset clears the pipeline, the queue, the running hash and byte count.
`default_nettype none

module murmur3_32_hash_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash
);
    import mm3_pkg::*;

    logic          q_push;
    logic          q_pop;
    mm3_item_t     push_item;
    mm3_item_t     head;
    mm3_q_status_t q_stat;

    mm3_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .word        (word),
        .valid_bytes (valid_bytes),
        .last        (last),
        .push        (q_push),
        .push_item   (push_item),
        .q_stat      (q_stat)
    );

    mm3_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    mm3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hash      (hash)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && head.last) |=> !q_pop ##1 !q_pop)
        else $error("back read the queue during finalization");
`endif

endmodule

`default_nettype wire

[sv/mm3_front.sv]
`default_nettype none

module mm3_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [31:0]         word,
    input  wire logic [2:0]          valid_bytes,
    input  wire logic                last,
    output logic                     push,
    output mm3_pkg::mm3_item_t       push_item,
    input  wire mm3_pkg::mm3_q_status_t q_stat
);
    import mm3_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_k_reg;
    logic [2:0]  s1_vb_reg;
    logic        s1_last_reg;
    logic        s2_valid_reg, s2_valid_next;
    logic [31:0] s2_k_reg;
    logic [2:0]  s2_vb_reg;
    logic        s2_last_reg;

    logic [2:0]  vb_sat;
    logic [31:0] masked;
    logic        s1_load;
    logic        s2_load;

    always_comb
    begin
        case (valid_bytes) inside
            [3'd4:3'd7]: vb_sat = MM3_FULL_WORD;
            default:     vb_sat = valid_bytes;
        endcase
        case (vb_sat)
            3'd1:    masked = {24'd0, word[7:0]};
            3'd2:    masked = {16'd0, word[15:0]};
            3'd3:    masked = {8'd0, word[23:0]};
            3'd4:    masked = word;
            default: masked = 32'd0;
        endcase
    end

    assign push      = s2_valid_reg && !q_stat.full;
    assign push_item = '{k: s2_k_reg, vb: s2_vb_reg, last: s2_last_reg};

    assign s2_load  = s1_valid_reg && (!s2_valid_reg || push);
    assign in_ready = !s1_valid_reg || s2_load;
    assign s1_load  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
        s2_valid_next = s2_load ? 1'b1 : (push ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // k * c1, then rotl 15 and * c2 one stage later
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_k_reg    <= masked * MM3_C1;
            s1_vb_reg   <= vb_sat;
            s1_last_reg <= last;
        end
        if (s2_load)
        begin
            s2_k_reg    <= {s1_k_reg[16:0], s1_k_reg[31:17]} * MM3_C2;
            s2_vb_reg   <= s1_vb_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

endmodule

`default_nettype wire

[sv/mm3_fifo.sv]
`default_nettype none

module mm3_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire mm3_pkg::mm3_item_t     push_item,
    input  wire logic                   pop,
    output mm3_pkg::mm3_item_t          head,
    output mm3_pkg::mm3_q_status_t      q_stat
);
    import mm3_pkg::*;

    mm3_item_t       mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? ((wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1)
                           : wr_ptr_reg;
        rd_ptr_next = pop ? ((rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1)
                          : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

[sv/mm3_back.sv]
`default_nettype none

module mm3_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mm3_pkg::mm3_item_t     head,
    input  wire mm3_pkg::mm3_q_status_t q_stat,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [31:0]                 hash
);
    import mm3_pkg::*;

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_MUL1 = 4'b0010,
        ST_MUL2 = 4'b0100,
        ST_OUT  = 4'b1000
    } mm3_back_state_t;

    mm3_back_state_t state_reg, state_next;
    logic [31:0]     h_reg, h_next;
    logic [31:0]     cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            zero_reg;
    logic [31:0]     fin_reg;
    logic [31:0]     hash_reg;

    logic [31:0] hx;
    logic [31:0] hr;
    logic [31:0] h_upd;
    logic [31:0] cnt_upd;
    logic [31:0] f0;
    logic [31:0] f1;
    logic        out_load;

    assign pop = (state_reg == ST_RUN) && !q_stat.empty;

    always_comb
    begin
        hx = h_reg ^ head.k;
        hr = {hx[18:0], hx[31:19]};
        case (head.vb)
            MM3_FULL_WORD: h_upd = {hr[29:0], 2'b00} + hr + MM3_N;
            3'd0:          h_upd = h_reg;
            default:       h_upd = hx;
        endcase
        cnt_upd = cnt_reg + {29'd0, head.vb};
        f0      = h_upd ^ cnt_upd;
        f0      = f0 ^ {16'd0, f0[31:16]};
        f1      = fin_reg ^ {13'd0, fin_reg[31:13]};
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (pop)
                begin
                    if (head.last)
                    begin
                        h_next     = '0;
                        cnt_next   = '0;
                        state_next = ST_MUL1;
                    end
                    else
                    begin
                        h_next   = h_upd;
                        cnt_next = cnt_upd;
                    end
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            h_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // fmix32: one multiply per cycle
    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            fin_reg  <= f0;
            zero_reg <= (cnt_upd == '0);
        end
        else if (state_reg == ST_MUL1)
            fin_reg <= fin_reg * MM3_F1;
        else if (state_reg == ST_MUL2)
            fin_reg <= f1 * MM3_F2;
        if (out_load)
            hash_reg <= zero_reg ? 32'd0 : (fin_reg ^ {16'd0, fin_reg[31:16]});
    end

    assign out_valid = out_valid_reg;
    assign hash      = hash_reg;

endmodule

`default_nettype wire

[sim/murmur3_32_hash_core_tb.sv]
`timescale 1ns / 100ps

module murmur3_32_hash_core_tb;

    localparam logic [31:0] KEY_MUL1  = 32'hcc9e2d51;
    localparam logic [31:0] KEY_MUL2  = 32'h1b873593;
    localparam logic [31:0] HASH_ADD  = 32'he6546b64;
    localparam logic [31:0] FMIX_MUL1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_MUL2 = 32'hc2b2ae35;
    localparam logic [2:0]  FULL_WORD_BYTES = 3'd4;
    localparam int ITEMS_TOTAL  = 1100;
    localparam int DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] word;
    logic [2:0]  valid_bytes;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] hash;

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;

    // running murmur3 state plus the hashes still owed by the block
    class mm3_hash_tracker;
        logic [31:0] run_hash;
        logic [31:0] byte_total;
        logic [31:0] pending_hashes[$];
        int          errors;

        function new();
            run_hash   = '0;
            byte_total = '0;
            errors     = 0;
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int r);
            return (x << r) | (x >> (32 - r));
        endfunction

        function logic [31:0] scramble(logic [31:0] k);
            k = k * KEY_MUL1;
            k = rotl(k, 15);
            k = k * KEY_MUL2;
            return k;
        endfunction

        function logic [31:0] avalanche(logic [31:0] x);
            x = x ^ (x >> 16);
            x = x * FMIX_MUL1;
            x = x ^ (x >> 13);
            x = x * FMIX_MUL2;
            x = x ^ (x >> 16);
            return x;
        endfunction

        function void take_word(logic [31:0] w, logic [2:0] vb, logic fin);
            int n;
            n = (vb > FULL_WORD_BYTES) ? 4 : int'(vb);
            if (n == 4)
            begin
                run_hash = run_hash ^ scramble(w);
                run_hash = rotl(run_hash, 13);
                run_hash = run_hash * 5 + HASH_ADD;
            end
            else if (n != 0)
            begin
                // tail: only the low bytes count, no h rotate step
                run_hash = run_hash ^ scramble(w & (32'hffffffff >> (8 * (4 - n))));
            end
            byte_total = byte_total + 32'(n);
            if (fin)
            begin
                if (byte_total == 0)
                    pending_hashes.push_back(32'h0);
                else
                    pending_hashes.push_back(avalanche(run_hash ^ byte_total));
                run_hash   = '0;
                byte_total = '0;
            end
        endfunction

        function void check_hash(logic [31:0] got);
            logic [31:0] want;
            if (pending_hashes.size() == 0)
            begin
                $error("hash: none expected, actual %h", got);
                errors++;
            end
            else
            begin
                want = pending_hashes.pop_front();
                if (got !== want)
                begin
                    $error("hash mismatch: expected %h actual %h", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    mm3_hash_tracker tracker = new();

    murmur3_32_hash_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .word        (word),
        .valid_bytes (valid_bytes),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hash        (hash)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // in_valid stays high between back-to-back transfers
    task automatic send_item(input logic [31:0] w, input logic [2:0] vb, input logic fin);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        word        <= w;
        valid_bytes <= vb;
        last        <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_word(w, vb, fin);
        items_sent++;
    endtask

    task automatic send_message(input bit noisy, input int nwords);
        int i;
        for (i = 0; i < nwords; i++)
            send_item($urandom(), noisy ? 3'($urandom_range(0, 7)) : FULL_WORD_BYTES, 1'b0);
        send_item($urandom(), 3'($urandom_range(0, noisy ? 7 : 4)), 1'b1);
    endtask

    initial
    begin
        int phase;
        int nwords;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        word          = '0;
        valid_bytes   = '0;
        last          = 1'b0;
        out_ready     = 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 84;
        items_sent    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message
        send_item($urandom(), 3'd0, 1'b1);
        // single-word messages of every length
        send_item(32'hffffffff, 3'd1, 1'b1);
        send_item(32'hffffffff, 3'd2, 1'b1);
        send_item(32'h00000000, 3'd3, 1'b1);
        send_item(32'hffffffff, 3'd4, 1'b1);
        // byte counts above four act as a full word
        send_item($urandom(), 3'd5, 1'b1);
        send_item($urandom(), 3'd6, 1'b1);
        send_item(32'hffffffff, 3'd7, 1'b1);
        // empty word in the middle of a message
        send_item(32'h00000000, 3'd4, 1'b0);
        send_item(32'hffffffff, 3'd0, 1'b0);
        send_item(32'hffffffff, 3'd4, 1'b0);
        send_item($urandom(), 3'd2, 1'b1);
        // partial word before the last one
        send_item(32'h5a5aa5a5, 3'd3, 1'b0);
        send_item(32'ha5a55a5a, 3'd4, 1'b0);
        send_item($urandom(), 3'd1, 1'b1);
        // empty final word after data
        send_item($urandom(), 3'd4, 1'b0);
        send_item($urandom(), 3'd0, 1'b1);
        // message made only of empty words
        send_item($urandom(), 3'd0, 1'b0);
        send_item($urandom(), 3'd0, 1'b1);
        send_item(32'h00000000, 3'd4, 1'b1);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 6 : 0;
            while (items_sent < (phase + 1) * ITEMS_TOTAL / 3)
            begin
                nwords = ($urandom_range(99) < 90) ? $urandom_range(0, 8)
                                                   : $urandom_range(9, 40);
                send_message($urandom_range(99) < 20, nwords);
            end
        end
        in_valid <= 1'b0;

        while (tracker.pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("murmur3_32_hash_core_tb OK");
        else
            $display("murmur3_32_hash_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_hash(hash);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #5000000;
        $display("murmur3_32_hash_core_tb NOT OK");
        $finish;
    end

endmodule

[files.f]
sv/mm3_pkg.sv
sv/mm3_front.sv
sv/mm3_fifo.sv
sv/mm3_back.sv
sv/murmur3_32_hash_core.sv
sim/murmur3_32_hash_core_tb.sv
